@@ sv/gmr_pkg.sv @@
// ============================================================================
// gmr_pkg: shared types and constants for the graded monomial rank unit
// Widths, datapath operation codes, controller states and the command
// bundle passed from the controller to the datapath.
// ============================================================================
package gmr_pkg;

    // monomial shape
    localparam int MAX_DEG    = 4;
    localparam int VAR_FIELDS = 4;
    localparam int DEG_LIMIT  = (MAX_DEG < VAR_FIELDS) ? MAX_DEG : VAR_FIELDS;

    // field widths
    localparam int DEG_W      = 3;
    localparam int VAR_W      = 17;
    localparam int K_W        = 12;
    localparam int RC_W       = 8;
    localparam int N_W        = 17;
    localparam int COL_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // datapath widths
    localparam int X_W        = VAR_W + 1;       // n + j - 1
    localparam int HALF_W     = COL_W / 2;       // multiplier operand slice
    localparam int MUL_W      = HALF_W + X_W;
    localparam int PROD_W     = COL_W + 2;       // partial binomial times factor
    localparam int ACC_W      = COL_W + 4;       // signed running sum
    localparam int SEL_W      = $clog2(VAR_FIELDS);
    localparam int FAC_W      = DEG_W;

    // divide by three, one chunk per cycle
    localparam int CHUNK_W    = 16;
    localparam int DV_W       = CHUNK_W + 2;
    localparam int DIV3_SHIFT = 19;
    localparam int DP_W       = DV_W + DIV3_SHIFT;
    localparam int DCNT_W     = $clog2(COL_W / CHUNK_W);
    localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = DIV3_SHIFT'(((1 << DIV3_SHIFT) + 1) / 3);
    localparam logic [DCNT_W-1:0]     DCNT_LAST  = DCNT_W'(COL_W / CHUNK_W - 1);

    localparam logic [DEG_W-1:0] DEG_LIMIT_C = DEG_W'(DEG_LIMIT);
    localparam logic [DEG_W-1:0] DEG_ZERO    = '0;
    localparam logic [FAC_W-1:0] POS_LAST    = FAC_W'(1);

    // divisor applied after each multiply step
    localparam logic [FAC_W-1:0] FAC_HALF    = FAC_W'(2);
    localparam logic [FAC_W-1:0] FAC_THIRD   = FAC_W'(3);
    localparam logic [FAC_W-1:0] FAC_QUARTER = FAC_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_K  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RANK   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = CFG_IDX_W'(2);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BAD,
        OP_INIT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SHR1,
        OP_SHR2,
        OP_DIV3,
        OP_ADD,
        OP_SUB
    } t_dp_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_dp_op           op;
        logic             side;     // 0: count for N, 1: count for the variable
        logic [SEL_W-1:0] var_sel;
        logic [SEL_W-1:0] fac_m1;   // j - 1 of the current multiply step
    } t_cmd;

endpackage

@@ sv/gmr_ctrl.sv @@
// ============================================================================
// gmr_ctrl: sequencer for the graded monomial rank unit
// Walks positions from the degree down to one, builds two multiset counts
// per position and issues one datapath operation per cycle.
// ============================================================================
module gmr_ctrl import gmr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEG_W-1:0] i_degree,
    output logic             o_busy,
    output logic             o_done,
    output t_cmd             o_cmd
);

    t_state              r_state, n_state;
    logic [FAC_W-1:0]    r_pos, n_pos;
    logic [FAC_W-1:0]    r_fac, n_fac;
    logic                r_side, n_side;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic                div_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_fac   <= '0;
            r_side  <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_fac   <= n_fac;
            r_side  <= n_side;
            r_dcnt  <= n_dcnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_fac         = r_fac;
        n_side        = r_side;
        n_dcnt        = r_dcnt;
        div_end       = 1'b1;
        o_cmd.op      = OP_NONE;
        o_cmd.side    = r_side;
        o_cmd.var_sel = SEL_W'(r_pos - POS_LAST);
        o_cmd.fac_m1  = SEL_W'(r_fac - POS_LAST);

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_degree > DEG_LIMIT_C) begin
                        o_cmd.op = OP_BAD;
                        n_state  = ST_DONE;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_pos    = i_degree;
                        n_side   = 1'b0;
                        n_state  = (i_degree == DEG_ZERO) ? ST_DONE : ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.op = OP_INIT;
                n_fac    = FAC_HALF;
                n_state  = (r_pos == POS_LAST) ? ST_ACC : ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_dcnt   = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                case (r_fac)
                    FAC_HALF:    o_cmd.op = OP_SHR1;
                    FAC_QUARTER: o_cmd.op = OP_SHR2;
                    FAC_THIRD: begin
                        o_cmd.op = OP_DIV3;
                        div_end  = (r_dcnt == DCNT_LAST);
                        n_dcnt   = r_dcnt + DCNT_W'(1);
                    end
                    default:     o_cmd.op = OP_NONE;
                endcase
                if (div_end) begin
                    if (r_fac == r_pos) begin
                        n_state = ST_ACC;
                    end else begin
                        n_fac   = r_fac + FAC_W'(1);
                        n_state = ST_MUL_LO;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.op = r_side ? OP_SUB : OP_ADD;
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = ST_INIT;
                end else begin
                    n_side = 1'b0;
                    if (r_pos == POS_LAST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_pos   = r_pos - POS_LAST;
                        n_state = ST_INIT;
                    end
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

@@ sv/gmr_datapath.sv @@
// ============================================================================
// gmr_datapath: arithmetic for the graded monomial rank unit
// Holds the configuration, the captured item, one shared 32x18 multiplier,
// a chunked exact divide by three and the signed running sum.
// ============================================================================
module gmr_datapath import gmr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [VAR_W-1:0]      i_var_0,
    input  logic [VAR_W-1:0]      i_var_1,
    input  logic [VAR_W-1:0]      i_var_2,
    input  logic [VAR_W-1:0]      i_var_3,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [COL_W-1:0]      o_column_index,
    output logic                  o_overflow
);

    logic [K_W-1:0]     r_lin_k;
    logic [RC_W-1:0]    r_rank;
    logic [RC_W-1:0]    r_groups;
    logic [VAR_W-1:0]   r_var [VAR_FIELDS];
    logic [N_W-1:0]     r_n_total;
    logic [COL_W-1:0]   r_b;
    logic [PROD_W-1:0]  r_prod;
    logic [1:0]         r_rem;
    logic [ACC_W-1:0]   r_acc;

    logic [2*RC_W-1:0]  rc_prod;
    logic [N_W-1:0]     n_total;
    logic [VAR_W-1:0]   base;
    logic [X_W-1:0]     factor;
    logic [HALF_W-1:0]  mul_a;
    logic [MUL_W-1:0]   mul_p;
    logic [DV_W-1:0]    div_v;
    logic [DP_W-1:0]    div_p;
    logic [CHUNK_W-1:0] div_q;
    logic [DV_W-1:0]    div_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_k  <= '0;
            r_rank   <= RC_W'(1);
            r_groups <= RC_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIN_K:  r_lin_k  <= i_cfg_data[K_W-1:0];
                CFG_RANK:   r_rank   <= i_cfg_data[RC_W-1:0];
                CFG_GROUPS: r_groups <= i_cfg_data[RC_W-1:0];
                default:    ;
            endcase
        end
    end

    assign rc_prod = (2*RC_W)'(r_rank) * (2*RC_W)'(r_groups);
    assign n_total = N_W'(r_lin_k) + N_W'(rc_prod);

    assign base   = i_cmd.side ? r_var[i_cmd.var_sel] : VAR_W'(r_n_total);
    assign factor = X_W'(base) + X_W'(i_cmd.fac_m1);

    assign mul_a = (i_cmd.op == OP_MUL_HI) ? r_b[COL_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign mul_p = MUL_W'(mul_a) * MUL_W'(factor);

    // top chunk with the running remainder; reciprocal is exact below 3 * 2^16
    assign div_v = {r_rem, r_prod[COL_W-1 -: CHUNK_W]};
    assign div_p = DP_W'(div_v) * DP_W'(DIV3_RECIP);
    assign div_q = div_p[DIV3_SHIFT +: CHUNK_W];
    assign div_r = div_v - (DV_W'(div_q) + DV_W'({div_q, 1'b0}));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_var[0]  <= i_var_0;
                r_var[1]  <= i_var_1;
                r_var[2]  <= i_var_2;
                r_var[3]  <= i_var_3;
                r_n_total <= n_total;
                r_acc     <= '0;
            end
            OP_BAD: begin
                // zero index with a nonzero top part flags overflow
                r_acc <= {{(ACC_W-COL_W-1){1'b0}}, 1'b1, {COL_W{1'b0}}};
            end
            OP_INIT: begin
                r_b <= COL_W'(base);
            end
            OP_MUL_LO: begin
                r_prod <= PROD_W'(mul_p);
            end
            OP_MUL_HI: begin
                r_prod <= r_prod + {mul_p[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
                r_rem  <= '0;
            end
            OP_SHR1: begin
                r_b <= r_prod[COL_W:1];
            end
            OP_SHR2: begin
                r_b <= r_prod[COL_W+1:2];
            end
            OP_DIV3: begin
                r_rem               <= div_r[1:0];
                r_prod[COL_W-1:0]   <= {r_prod[COL_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                r_b                 <= {r_b[COL_W-CHUNK_W-1:0], div_q};
            end
            OP_ADD: begin
                r_acc <= r_acc + ACC_W'(r_b);
            end
            OP_SUB: begin
                r_acc <= r_acc - ACC_W'(r_b);
            end
            default: ;
        endcase
    end

    assign o_column_index = r_acc[COL_W-1:0];
    assign o_overflow     = |r_acc[ACC_W-1:COL_W];

endmodule

@@ sv/grlex_monomial_rank_unit.sv @@
// ============================================================================
// grlex_monomial_rank_unit: graded monomial column index
// Ranks a monomial of degree 0..4 in graded order over N = k + r*c variables.
// ============================================================================
// Result: the strobe comes in the cycle after accept for degree 0 or a degree
//   above 4; for degree 1 to 4 it follows the multiply, divide and accumulate steps.
// Throughput: one item at a time; the unit stays busy through the strobe, its
//   pace set by the shared 32x18 multiplier (two passes per factor) and
//   the divide by three, which retires one 16-bit chunk per cycle.
// Reset: synchronous, active low; idles the sequencer, sets k = 0, r = 1, c = 1.
module grlex_monomial_rank_unit import gmr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  logic [DEG_W-1:0]      i_degree,
    input  logic [VAR_W-1:0]      i_var_0,
    input  logic [VAR_W-1:0]      i_var_1,
    input  logic [VAR_W-1:0]      i_var_2,
    input  logic [VAR_W-1:0]      i_var_3,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // result
    output logic                  o_result_valid,
    output logic [COL_W-1:0]      o_column_index,
    output logic                  o_overflow
);

    t_cmd cmd;
    logic cfg_we;

    // Take register writes only while no item is in flight.
    assign o_cfg_ready = ~busy;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // Sequencer: per position, build C(N+i-1,i) then C(v+i-1,i) by repeated
    // multiply and exact divide, and add or subtract each into the sum.
    gmr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_degree (i_degree),
        .o_busy   (busy),
        .o_done   (o_result_valid),
        .o_cmd    (cmd)
    );

    // Datapath captures the variables on the accept cycle and holds the
    // result steady from the strobe until the next item is accepted.
    gmr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_var_0        (i_var_0),
        .i_var_1        (i_var_1),
        .i_var_2        (i_var_2),
        .i_var_3        (i_var_3),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_column_index (o_column_index),
        .o_overflow     (o_overflow)
    );

    // An accepted item keeps the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting an item");

    // The result strobe lasts a single cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // An oversized degree returns at once with a zero index and overflow.
    a_bad_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_degree > DEG_LIMIT_C))
            |=> (o_result_valid && o_overflow && (o_column_index == '0)))
        else $error("oversized degree not flagged");

    // Degree zero returns at once with index zero and no overflow.
    a_zero_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_degree == DEG_ZERO))
            |=> (o_result_valid && !o_overflow && (o_column_index == '0)))
        else $error("degree zero result wrong");

endmodule
